/* hdl/host_bridge_config_space_assert.svh */
// Assertion macros for the host bridge configuration space RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef HOST_BRIDGE_CONFIG_SPACE_ASSERT_SVH
`define HOST_BRIDGE_CONFIG_SPACE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define HBCS_ASSERT_IMP(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("host bridge config space: implication check failed");
// next-cycle implication
`define HBCS_ASSERT_NXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("host bridge config space: next-cycle check failed");
`else
`define HBCS_ASSERT_IMP(name, clk, rst, pre, post)
`define HBCS_ASSERT_NXT(name, clk, rst, pre, post)
`endif
`endif

/* hdl/hbcs_pkg.sv */
// Shared types, register offsets and reset contents for the host bridge
// configuration space. No dependencies.
`timescale 1ns / 1ps
package hbcs_pkg;

  localparam int SPACE_BYTES_DEF = 256;

  typedef enum logic [2:0] {
    KIND_READ      = 3'd0,
    KIND_WRITE     = 3'd1,
    KIND_SMM_ENTER = 3'd2,
    KIND_SMM_EXIT  = 3'd3,
    KIND_RESET     = 3'd4
  } kind_t;

  // register offsets
  localparam logic [7:0] OFF_DEVID_HI = 8'h03;
  localparam logic [7:0] OFF_CMD_LO   = 8'h04;
  localparam logic [7:0] OFF_CMD_HI   = 8'h05;
  localparam logic [7:0] OFF_STAT_LO  = 8'h06;
  localparam logic [7:0] OFF_STAT_HI  = 8'h07;
  localparam logic [7:0] OFF_REVID    = 8'h08;
  localparam logic [7:0] OFF_CLS      = 8'h0c;
  localparam logic [7:0] OFF_HDR      = 8'h0e;
  localparam logic [7:0] OFF_RO_FIRST = 8'h10;
  localparam logic [7:0] OFF_RO_LAST  = 8'h4e;
  localparam logic [7:0] OFF_PAM0     = 8'h59;
  localparam logic [7:0] OFF_PAM1     = 8'h5a;
  localparam logic [7:0] OFF_PAM6     = 8'h5f;
  localparam logic [7:0] OFF_SMRAM    = 8'h72;

  // chipset reset behaves as this write to PAM0
  localparam logic [7:0] PAM0_RESET_WORD = 8'h0f;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] fn;
    logic [7:0] off;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        map_valid;
    logic [19:0] map_base;
    logic [17:0] map_size;
    logic        reads_internal;
    logic        writes_internal;
    logic        flush_translation;
  } res_t;

  typedef struct packed {
    logic [1:0] n_res;
    res_t       res0;
    res_t       res1;
    logic       wr_en;
    logic [7:0] wr_data;
  } eval_t;

  // power-on contents of the configuration space
  function automatic logic [7:0] reset_byte(logic [7:0] a);
    logic [7:0] b;
    case (a)
      8'h00: b = 8'h86;
      8'h01: b = 8'h80;
      8'h02: b = 8'h50;
      8'h03: b = 8'h12;
      8'h04: b = 8'h06;
      8'h07: b = 8'h02;
      8'h0b: b = 8'h06;
      8'h51: b = 8'h20;
      8'h52: b = 8'hb5;
      8'h56: b = 8'h52;
      8'h59: b = 8'h40;
      8'h5a, 8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h5f: b = 8'h44;
      8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67: b = 8'h02;
      8'h68: b = 8'h11;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hdl/hbcs_eval.sv */
// Per-word evaluation: write masking, SMRAM lock handling, PAM/SMRAM
// routing results. Depends on hbcs_pkg.
`timescale 1ns / 1ps
module hbcs_eval (
  input  hbcs_pkg::item_t    item,
  input  logic [7:0]         old,
  output hbcs_pkg::eval_t    ev
);
  import hbcs_pkg::*;

  logic       ro;
  logic       pam_sub;
  logic [2:0] pam_idx;
  logic [7:0] pam_rel;
  logic [7:0] v;
  logic [7:0] diff;
  logic [19:0] pam_base;
  res_t       lo_res, hi_res;

  function automatic res_t map_res(logic [19:0] base, logic [17:0] size,
                                   logic [1:0] route, logic flush);
    res_t r;
    r = '0;
    r.map_valid = 1'b1;
    r.map_base = base;
    r.map_size = size;
    r.reads_internal = route[0];
    r.writes_internal = route[1];
    r.flush_translation = flush;
    return r;
  endfunction

  always_comb begin
    ro = (item.off <= OFF_DEVID_HI)
      || (item.off >= OFF_REVID && item.off <= OFF_CLS)
      || (item.off == OFF_HDR)
      || (item.off >= OFF_RO_FIRST && item.off <= OFF_RO_LAST);

    case (item.off)
      OFF_CMD_LO: v = (item.data & 8'h02) | 8'h04;
      OFF_CMD_HI, OFF_STAT_LO: v = 8'h00;
      OFF_STAT_HI: v = (item.data & 8'h80) | 8'h02;
      OFF_SMRAM: begin
        v = (item.data & 8'h78) | 8'h02 | (old & 8'h10);
        // lock set: open/enable frozen, enable keeps its old value
        if (v[4]) begin
          v = (v & ~8'h48) | (old & 8'h08);
        end
      end
      default: v = item.data;
    endcase
    diff = old ^ v;

    pam_sub  = (item.off >= OFF_PAM1) && (item.off <= OFF_PAM6);
    pam_rel  = item.off - OFF_PAM1;
    pam_idx  = pam_rel[2:0];
    pam_base = 20'hc0000 + 20'({pam_idx, 15'd0});
    lo_res   = map_res(pam_base, 18'h04000, v[1:0], 1'b1);
    hi_res   = map_res(pam_base + 20'h04000, 18'h04000, v[5:4], 1'b1);
  end

  always_comb begin
    ev = '0;
    case (item.kind)
      KIND_READ: begin
        ev.n_res = 2'd1;
        ev.res0.read_data = (item.fn != 3'd0) ? 8'hff : old;
      end
      KIND_WRITE, KIND_RESET: begin
        if ((item.kind == KIND_RESET || item.fn == 3'd0) && !ro) begin
          ev.wr_en = 1'b1;
          ev.wr_data = v;
          if (item.off == OFF_PAM0) begin
            if (diff[7:4] != 4'd0) begin
              ev.n_res = 2'd1;
              ev.res0 = map_res(20'hf0000, 18'h10000, v[5:4], 1'b1);
            end
          end else if (pam_sub) begin
            if (diff[3:0] != 4'd0) begin
              ev.res0 = lo_res;
              ev.res1 = hi_res;
              ev.n_res = (diff[7:4] != 4'd0) ? 2'd2 : 2'd1;
            end else if (diff[7:4] != 4'd0) begin
              ev.res0 = hi_res;
              ev.n_res = 2'd1;
            end
          end else if (item.off == OFF_SMRAM) begin
            if (diff[6]) begin
              ev.n_res = 2'd1;
              ev.res0 = map_res(20'ha0000, 18'h20000, {v[6], v[6]}, 1'b0);
            end
          end
        end
      end
      KIND_SMM_ENTER, KIND_SMM_EXIT: begin
        // old holds the SMRAM control byte here
        if (old[3]) begin
          ev.n_res = 2'd1;
          ev.res0 = map_res(20'ha0000, 18'h20000,
                            {2{item.kind == KIND_SMM_ENTER}}, 1'b0);
        end
      end
      default: ev = '0;
    endcase
  end

endmodule

/* hdl/host_bridge_config_space.sv */
// Top level of the host bridge configuration space: input stage, byte store,
// result register. Depends on hbcs_pkg, hbcs_eval and the assertion header.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid/in_ready) carries one word per event: kind,
//   function_number, reg_offset, write_data. Output channel
//   (out_valid/out_ready) carries result words; last marks the final result
//   of an event.
//   A config read always yields one result. Writes, SMM events and chipset
//   reset yield zero, one or two routing results (PAM or SMRAM remaps).
//   An accepted word is registered in the stage and hands its first result
//   to the output register (out_valid high from then on). An event with two
//   results holds the stage until both are loaded; otherwise a new word is
//   taken every cycle unless the output stalls. The rate is set by the single
//   stage register that hands one result per cycle to the output register.
//   The byte store is read at acceptance with registered read data; a write
//   retiring on the same edge is forwarded through a one-entry bypass.
//   Reset: rst clears the per-byte valid bits, so every byte reads as its
//   power-on value at once; no clearing sweep is needed.
//   Stall: when out_ready is low the output register holds its word, the
//   stage stalls, and in_ready drops once the stage cannot retire.
`include "host_bridge_config_space_assert.svh"
module host_bridge_config_space #(
  parameter int SPACE_BYTES = hbcs_pkg::SPACE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [2:0]  function_number,
  input  logic [7:0]  reg_offset,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        map_valid,
  output logic [19:0] map_base,
  output logic [17:0] map_size,
  output logic        reads_internal,
  output logic        writes_internal,
  output logic        flush_translation,
  output logic        last
);
  import hbcs_pkg::*;

  localparam int ADDR_W = $clog2(SPACE_BYTES);

  // byte store, valid bits, bypass
  logic [7:0]             mem [SPACE_BYTES];
  logic [SPACE_BYTES-1:0] vld;
  logic [7:0]             mem_q;
  logic                   vld_q;
  logic                   byp_valid;
  logic [ADDR_W-1:0]      byp_addr;
  logic [7:0]             byp_data;

  // stage
  item_t             item_next;
  item_t             s1;
  logic              s1_valid;
  logic              s1_idx;
  logic [7:0]        old;
  eval_t             ev;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  logic accept;
  logic out_load;
  logic s1_done;
  logic mem_we;
  res_t cur;

  // fold event kinds onto the byte they touch
  always_comb begin
    item_next.kind = kind_t'(kind);
    item_next.fn   = function_number;
    item_next.off  = reg_offset;
    item_next.data = write_data;
    case (kind_t'(kind))
      KIND_SMM_ENTER, KIND_SMM_EXIT: item_next.off = OFF_SMRAM;
      KIND_RESET: begin
        item_next.off  = OFF_PAM0;
        item_next.data = PAM0_RESET_WORD;
        item_next.fn   = 3'd0;
      end
      default: item_next.off = reg_offset;
    endcase
  end

  assign rd_addr = item_next.off[ADDR_W-1:0];
  assign wr_addr = s1.off[ADDR_W-1:0];

  // current byte value: bypass, then store, then power-on value
  assign old = (byp_valid && byp_addr == wr_addr) ? byp_data
             : (vld_q ? mem_q : reset_byte(s1.off));

  hbcs_eval u_eval (
    .item (s1),
    .old  (old),
    .ev   (ev)
  );

  assign out_load = s1_valid && (ev.n_res != 2'd0) && (!out_valid || out_ready);
  assign s1_done  = s1_valid && ((ev.n_res == 2'd0)
                  || (out_load && (s1_idx || ev.n_res == 2'd1)));
  assign in_ready = !s1_valid || s1_done;
  assign accept   = in_valid && in_ready;
  assign mem_we   = s1_done && ev.wr_en;
  assign cur      = s1_idx ? ev.res1 : ev.res0;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= mem[rd_addr];
      vld_q <= vld[rd_addr];
      s1    <= item_next;
    end
    if (mem_we) begin
      mem[wr_addr] <= ev.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      byp_valid <= 1'b0;
    end else if (mem_we) begin
      vld[wr_addr] <= 1'b1;
      byp_valid    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byp_addr <= wr_addr;
      byp_data <= ev.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_idx   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_done) begin
        s1_idx <= 1'b0;
      end else if (out_load) begin
        s1_idx <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_data         <= cur.read_data;
      map_valid         <= cur.map_valid;
      map_base          <= cur.map_base;
      map_size          <= cur.map_size;
      reads_internal    <= cur.reads_internal;
      writes_internal   <= cur.writes_internal;
      flush_translation <= cur.flush_translation;
      last              <= s1_idx || (ev.n_res == 2'd1);
    end
  end

  // second result only exists for a two-result word
  `HBCS_ASSERT_IMP(a_idx_two, clk, rst, s1_idx, s1_valid && ev.n_res == 2'd2)
  // store is written only as a word retires
  `HBCS_ASSERT_IMP(a_we_done, clk, rst, mem_we, s1_done && s1_valid)
  // an accepted word occupies the stage next cycle
  `HBCS_ASSERT_NXT(a_acc_s1, clk, rst, accept, s1_valid)
  // a read always yields exactly one result
  `HBCS_ASSERT_IMP(a_read_one, clk, rst, s1_valid && s1.kind == KIND_READ,
                   ev.n_res == 2'd1 && !ev.wr_en)

endmodule

/* test/testbench.sv */
// Self-checking testbench for host_bridge_config_space: config reads and writes,
// PAM and SMRAM remap results, SMM events and chipset reset events.
// Depends on hbcs_pkg and the host_bridge_config_space RTL.
`timescale 1ns / 1ps
module testbench;
  import hbcs_pkg::*;

  // Hard stop.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_OPEN_WORDS   = 1200;
  localparam int RANDOM_LOCKED_WORDS = 300;
  localparam int MAX_PRINTED_ERRORS  = 30;

  // Kinds above chipset reset carry no meaning and must be ignored.
  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

  // Forced and kept bits of the command, status and SMRAM bytes.
  localparam logic [7:0] CMD_KEEP     = 8'h02;
  localparam logic [7:0] CMD_FORCE    = 8'h04;
  localparam logic [7:0] STAT_KEEP    = 8'h80;
  localparam logic [7:0] STAT_FORCE   = 8'h02;
  localparam logic [7:0] SMRAM_WMASK  = 8'h78;
  localparam logic [7:0] SMRAM_FORCE  = 8'h02;
  localparam logic [7:0] SMRAM_LOCK   = 8'h10;
  localparam logic [7:0] SMRAM_OPEN   = 8'h40;
  localparam logic [7:0] SMRAM_EN     = 8'h08;
  localparam logic [7:0] READ_MISS    = 8'hff;

  // Region map below 1MB.
  localparam logic [19:0] PAM_BIOS_BASE  = 20'hf0000;
  localparam logic [17:0] PAM_BIOS_SIZE  = 18'h10000;
  localparam logic [19:0] PAM_SEG_BASE   = 20'hc0000;
  localparam logic [19:0] PAM_SEG_STRIDE = 20'h08000;
  localparam logic [17:0] PAM_SEG_SIZE   = 18'h04000;
  localparam logic [19:0] SMRAM_BASE     = 20'ha0000;
  localparam logic [17:0] SMRAM_SIZE     = 18'h20000;

  // route bit 0 = reads to DRAM, bit 1 = writes to DRAM
  localparam logic [1:0] ROUTE_DRAM = 2'b11;
  localparam logic [1:0] ROUTE_BUS  = 2'b00;

  // Power-on image as {offset, value}; everything else is zero.
  localparam int N_DEFAULTS = 26;
  localparam logic [15:0] DEFAULTS [N_DEFAULTS] = '{
    16'h00_86, 16'h01_80, 16'h02_50, 16'h03_12, 16'h04_06, 16'h07_02,
    16'h0b_06, 16'h51_20, 16'h52_b5, 16'h56_52, 16'h59_40,
    16'h5a_44, 16'h5b_44, 16'h5c_44, 16'h5d_44, 16'h5e_44, 16'h5f_44,
    16'h60_02, 16'h61_02, 16'h62_02, 16'h63_02, 16'h64_02, 16'h65_02,
    16'h66_02, 16'h67_02, 16'h68_11
  };

  typedef struct packed {
    logic [7:0]  read_data;
    logic        map_valid;
    logic [19:0] map_base;
    logic [17:0] map_size;
    logic        reads_int;
    logic        writes_int;
    logic        flush;
    logic        last_flag;
  } bridge_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  kind = '0;
  logic [2:0]  function_number = '0;
  logic [7:0]  reg_offset = '0;
  logic [7:0]  write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;
  logic        map_valid;
  logic [19:0] map_base;
  logic [17:0] map_size;
  logic        reads_internal;
  logic        writes_internal;
  logic        flush_translation;
  logic        last;

  // Predictor state: our own copy of the 256-byte space.
  logic [7:0]     cfg_image [0:255];
  bridge_result_t route_buf [2];
  int             route_n;
  bridge_result_t pending_results [$];

  int err_count      = 0;
  int results_seen   = 0;
  int words_sent     = 0;
  int reads_sent     = 0;
  int routes_seen    = 0;
  int cycle_count    = 0;
  int burst_left     = 0;

  logic [15:0] stall_pat = 16'hffff;
  logic [5:0]  stall_ph  = '0;

  host_bridge_config_space dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .kind              (kind),
    .function_number   (function_number),
    .reg_offset        (reg_offset),
    .write_data        (write_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .read_data         (read_data),
    .map_valid         (map_valid),
    .map_base          (map_base),
    .map_size          (map_size),
    .reads_internal    (reads_internal),
    .writes_internal   (writes_internal),
    .flush_translation (flush_translation),
    .last              (last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  task automatic load_power_on_image();
    foreach (cfg_image[i]) cfg_image[i] = 8'h00;
    foreach (DEFAULTS[i]) cfg_image[DEFAULTS[i][15:8]] = DEFAULTS[i][7:0];
  endtask

  // Queue one routing change for the word being predicted; at most two.
  function automatic void post_route(logic [19:0] base, logic [17:0] size,
                                     logic [1:0] route, logic flush);
    bridge_result_t r;
    r = '0;
    r.map_valid  = 1'b1;
    r.map_base   = base;
    r.map_size   = size;
    r.reads_int  = route[0];
    r.writes_int = route[1];
    r.flush      = flush;
    if (route_n < 2) begin
      route_buf[route_n] = r;
      route_n++;
    end
  endfunction

  // Masked store into the space, with any remap it causes.
  function automatic void apply_cfg_write(logic [7:0] off, logic [7:0] din);
    logic [7:0]  v;
    logic [7:0]  prev;
    logic [19:0] seg;
    v    = din;
    prev = cfg_image[off];
    // identity bytes, header bytes and the 10..4E block never change
    if (off >= OFF_RO_FIRST && off <= OFF_RO_LAST) return;
    if (off <= OFF_DEVID_HI || (off >= OFF_REVID && off <= OFF_CLS) || off == OFF_HDR)
      return;
    if (off == OFF_CMD_LO) begin
      v = (v & CMD_KEEP) | CMD_FORCE;
    end else if (off == OFF_CMD_HI || off == OFF_STAT_LO) begin
      v = 8'h00;
    end else if (off == OFF_STAT_HI) begin
      v = (v & STAT_KEEP) | STAT_FORCE;
    end else if (off == OFF_PAM0) begin
      // only the high nibble of PAM0 maps a region (the BIOS segment)
      if (v[7:4] != prev[7:4]) post_route(PAM_BIOS_BASE, PAM_BIOS_SIZE, v[5:4], 1'b1);
    end else if (off >= OFF_PAM1 && off <= OFF_PAM6) begin
      // low nibble first, then high nibble; each covers 16K
      seg = PAM_SEG_BASE + (off - OFF_PAM1) * PAM_SEG_STRIDE;
      if (v[3:0] != prev[3:0]) post_route(seg, PAM_SEG_SIZE, v[1:0], 1'b1);
      if (v[7:4] != prev[7:4]) post_route(seg + PAM_SEG_SIZE, PAM_SEG_SIZE, v[5:4], 1'b1);
    end else if (off == OFF_SMRAM) begin
      // lock is sticky; once set, open and enable are frozen
      v = (v & SMRAM_WMASK) | SMRAM_FORCE | (prev & SMRAM_LOCK);
      if ((v & SMRAM_LOCK) != 0)
        v = (v & ~(SMRAM_OPEN | SMRAM_EN)) | (prev & SMRAM_EN);
      if (((prev ^ v) & SMRAM_OPEN) != 0)
        post_route(SMRAM_BASE, SMRAM_SIZE,
                   ((v & SMRAM_OPEN) != 0) ? ROUTE_DRAM : ROUTE_BUS, 1'b0);
    end
    cfg_image[off] = v;
  endfunction

  // Work out every result of one accepted word and append them in order.
  function automatic void predict_word(logic [2:0] k, logic [2:0] f,
                                       logic [7:0] o, logic [7:0] d);
    bridge_result_t rd_res;
    route_n = 0;
    case (k)
      KIND_READ: begin
        rd_res           = '0;
        rd_res.read_data = (f != 3'd0) ? READ_MISS : cfg_image[o];
        rd_res.last_flag = 1'b1;
        pending_results.push_back(rd_res);
        reads_sent++;
      end
      KIND_WRITE:     if (f == 3'd0) apply_cfg_write(o, d);
      KIND_SMM_ENTER: if ((cfg_image[OFF_SMRAM] & SMRAM_EN) != 0)
                        post_route(SMRAM_BASE, SMRAM_SIZE, ROUTE_DRAM, 1'b0);
      KIND_SMM_EXIT:  if ((cfg_image[OFF_SMRAM] & SMRAM_EN) != 0)
                        post_route(SMRAM_BASE, SMRAM_SIZE, ROUTE_BUS, 1'b0);
      KIND_RESET:     apply_cfg_write(OFF_PAM0, PAM0_RESET_WORD);
      default: ;
    endcase
    for (int i = 0; i < route_n; i++) begin
      route_buf[i].last_flag = (i == route_n - 1);
      pending_results.push_back(route_buf[i]);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts of words with random gaps between bursts. Called at a
  // rising edge; returns at the edge where the word was taken.
  // ---------------------------------------------------------------------
  task automatic send_word(logic [2:0] k, logic [2:0] f, logic [7:0] o, logic [7:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid        <= 1'b1;
    kind            <= k;
    function_number <= f;
    reg_offset      <= o;
    write_data      <= d;
    do @(posedge clk); while (!in_ready);
    predict_word(k, f, o, d);
    words_sent++;
    burst_left--;
  endtask

  // Random word, weighted toward PAM and SMRAM traffic so remaps happen often.
  task automatic send_random_word(bit allow_lock);
    logic [2:0] k;
    logic [2:0] f;
    logic [7:0] o;
    logic [7:0] d;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35)      k = KIND_READ;
    else if (sel < 75) k = KIND_WRITE;
    else if (sel < 83) k = KIND_SMM_ENTER;
    else if (sel < 91) k = KIND_SMM_EXIT;
    else if (sel < 96) k = KIND_RESET;
    else               k = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
    f = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
    sel = $urandom_range(0, 99);
    if (sel < 35)      o = 8'($urandom_range(OFF_PAM0, OFF_PAM6));
    else if (sel < 50) o = OFF_SMRAM;
    else if (sel < 60) o = 8'($urandom_range(OFF_CMD_LO, OFF_STAT_HI));
    else if (sel < 70) o = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, OFF_RO_FIRST))
                                                       : 8'($urandom_range(OFF_RO_LAST, 8'h50));
    else               o = 8'($urandom);
    d = 8'($urandom);
    // keep SMRAM unlocked for the open phase, or open/enable freeze for good
    if (!allow_lock && o == OFF_SMRAM) d = d & ~SMRAM_LOCK;
    send_word(k, f, o, d);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_identity_reads();
    send_word(KIND_READ, 3'd0, 8'h00, 8'h00);
    send_word(KIND_READ, 3'd0, OFF_DEVID_HI, 8'hff);
    send_word(KIND_READ, 3'd0, OFF_PAM6, 8'h00);   // corrected default
    send_word(KIND_READ, 3'd0, 8'hff, 8'h5a);
  endtask

  task automatic test_function_select();
    send_word(KIND_READ, 3'd7, 8'h00, 8'h00);      // absent function reads all ones
    send_word(KIND_WRITE, 3'd3, OFF_PAM1, 8'h00);  // dropped: no remap
    send_word(KIND_READ, 3'd0, OFF_PAM1, 8'h00);
  endtask

  task automatic test_readonly_and_command();
    send_word(KIND_WRITE, 3'd0, 8'h00, 8'hff);
    send_word(KIND_WRITE, 3'd0, OFF_RO_FIRST, 8'hff);
    send_word(KIND_WRITE, 3'd0, OFF_RO_LAST, 8'hff);
    send_word(KIND_WRITE, 3'd0, OFF_RO_LAST + 8'd1, 8'ha5);
    send_word(KIND_WRITE, 3'd0, OFF_CMD_LO, 8'hff);
    send_word(KIND_WRITE, 3'd0, OFF_STAT_HI, 8'hff);
    send_word(KIND_READ, 3'd0, OFF_RO_FIRST, 8'h00);
    send_word(KIND_READ, 3'd0, OFF_RO_LAST + 8'd1, 8'h00);
    send_word(KIND_READ, 3'd0, OFF_CMD_LO, 8'h00);
    send_word(KIND_READ, 3'd0, OFF_STAT_HI, 8'h00);
  endtask

  task automatic test_pam_remap();
    send_word(KIND_WRITE, 3'd0, OFF_PAM0, 8'h30);  // BIOS segment
    send_word(KIND_WRITE, 3'd0, OFF_PAM1, 8'h33);  // both nibbles: two results
    send_word(KIND_WRITE, 3'd0, OFF_PAM6, 8'hf0);
    send_word(KIND_RESET, 3'd0, 8'h00, 8'h00);
    send_word(KIND_READ, 3'd0, OFF_PAM0, 8'h00);
  endtask

  task automatic test_smram_and_smm();
    send_word(KIND_SMM_ENTER, 3'd0, 8'h00, 8'h00); // enable clear: nothing
    send_word(KIND_WRITE, 3'd0, OFF_SMRAM, 8'h48); // open and enable
    send_word(KIND_SMM_ENTER, 3'd0, 8'h00, 8'h00);
    send_word(KIND_SMM_EXIT, 3'd0, 8'h00, 8'h00);
    send_word(KIND_WRITE, 3'd0, OFF_SMRAM, 8'h00); // close
  endtask

  task automatic test_unused_kinds();
    send_word(KIND_UNUSED_LAST, 3'd0, OFF_PAM1, 8'hff);
  endtask

  task automatic test_random_traffic(int n_words, bit allow_lock);
    for (int i = 0; i < n_words; i++) send_random_word(allow_lock);
  endtask

  task automatic test_smram_lock();
    send_word(KIND_WRITE, 3'd0, OFF_SMRAM, 8'h4c);
    send_word(KIND_WRITE, 3'd0, OFF_SMRAM, 8'h58); // lock: open drops, enable kept
    send_word(KIND_WRITE, 3'd0, OFF_SMRAM, 8'hff); // frozen
    send_word(KIND_READ, 3'd0, OFF_SMRAM, 8'h00);
    send_word(KIND_SMM_ENTER, 3'd0, 8'h00, 8'h00);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stalls follow a 16-bit pattern that is redrawn whenever the
  // 6-bit phase counter wraps; some patterns never stall.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    stall_ph <= stall_ph + 6'd1;
    if (stall_ph == '1) begin
      case ($urandom_range(0, 3))
        0:       stall_pat <= 16'hffff;
        1:       stall_pat <= 16'($urandom) | 16'h0001;
        2:       stall_pat <= (16'($urandom) & 16'($urandom)) | 16'h0001;
        default: stall_pat <= 16'($urandom) | 16'($urandom);
      endcase
    end
    out_ready <= stall_pat[stall_ph[3:0]];
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTED_ERRORS)
      $display("[%0t] result %0d: %s got %0h expected %0h", $realtime, results_seen, what,
               got, want);
  endtask

  // Checker: every accepted output word against the oldest prediction.
  always @(posedge clk) begin : check_results
    bridge_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, read_data", 32'(read_data), 0);
      end else begin
        e = pending_results.pop_front();
        if (read_data !== e.read_data)
          report_mismatch("read_data", 32'(read_data), 32'(e.read_data));
        if (map_valid !== e.map_valid)
          report_mismatch("map_valid", 32'(map_valid), 32'(e.map_valid));
        if (map_base !== e.map_base)
          report_mismatch("map_base", 32'(map_base), 32'(e.map_base));
        if (map_size !== e.map_size)
          report_mismatch("map_size", 32'(map_size), 32'(e.map_size));
        if (reads_internal !== e.reads_int)
          report_mismatch("reads_internal", 32'(reads_internal), 32'(e.reads_int));
        if (writes_internal !== e.writes_int)
          report_mismatch("writes_internal", 32'(writes_internal), 32'(e.writes_int));
        if (flush_translation !== e.flush)
          report_mismatch("flush_translation", 32'(flush_translation), 32'(e.flush));
        if (last !== e.last_flag)
          report_mismatch("last", 32'(last), 32'(e.last_flag));
        if (e.map_valid) routes_seen++;
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    load_power_on_image();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed
    test_identity_reads();
    test_function_select();
    test_readonly_and_command();
    test_pam_remap();
    test_smram_and_smm();
    test_unused_kinds();
    // random, SMRAM kept unlocked
    test_random_traffic(RANDOM_OPEN_WORDS, 1'b0);
    // lock SMRAM, then keep hammering the frozen register
    test_smram_lock();
    test_random_traffic(RANDOM_LOCKED_WORDS, 1'b1);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // let any stray output word show up
    repeat (16) @(posedge clk);

    if (pending_results.size() != 0)
      report_mismatch("words never delivered", pending_results.size(), 0);
    $display("%0d words sent (%0d reads), %0d results checked, %0d of them remaps",
             words_sent, reads_sent, results_seen, routes_seen);
    $display("%0d mismatches in %0d cycles", err_count, cycle_count);
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
